### rtl/kcfe_pkg.sv
// ----------------------------------------------------------------------------
// kcfe_pkg: shared definitions for the keypad channel frame encoder
// Widths, slot codes, payload masks and the slot value chooser.
// ----------------------------------------------------------------------------
`default_nettype none

package kcfe_pkg;

  localparam int unsigned KEY_W    = 16;
  localparam int unsigned CODE_W   = 12;
  localparam int unsigned VAL_W    = 6;
  localparam int unsigned FIELD_W  = 5;

  localparam int unsigned REPEATS  = 3;
  localparam int unsigned REP_W    = $clog2(REPEATS + 1);

  localparam logic [CODE_W-1:0] SYNC_RESET = 12'ha40;
  localparam logic [CODE_W-1:0] CODE_TOP   = 12'd2719;
  localparam logic [CODE_W-1:0] CODE_BASE  = 12'h020;

  // floor(y / 17) == (y * RECIP_17) >> RECIP_SHIFT for y < 2^16
  localparam int unsigned RECIP_SHIFT = 20;
  localparam logic [15:0] RECIP_17    = 16'd61681;

  localparam logic [1:0] SLOT_SYNC = 2'd0;
  localparam logic [1:0] SLOT_LOW  = 2'd1;
  localparam logic [1:0] SLOT_MID  = 2'd2;
  localparam logic [1:0] SLOT_HIGH = 2'd3;

  localparam logic [KEY_W-1:0] CLR_LOW  = 16'hffc0;
  localparam logic [KEY_W-1:0] CLR_MID  = 16'hf83f;
  localparam logic [KEY_W-1:0] CLR_HIGH = 16'h07ff;

  // Set bit 5 when it moves the value further from the previous slot.
  function automatic logic [VAL_W-1:0] pick_wider(
    input logic [VAL_W-1:0]   prev,
    input logic [FIELD_W-1:0] cur
  );
    logic [VAL_W-1:0] plain;
    logic [VAL_W-1:0] alt;
    logic [VAL_W-1:0] d1;
    logic [VAL_W-1:0] d2;
    plain = {1'b0, cur};
    alt   = {1'b1, cur};
    d1    = (prev >= plain) ? (prev - plain) : (plain - prev);
    d2    = (prev >= alt) ? (prev - alt) : (alt - prev);
    return (d2 > d1) ? alt : plain;
  endfunction

endpackage

`default_nettype wire

### rtl/kcfe_code_map.sv
// ----------------------------------------------------------------------------
// kcfe_code_map: raw pulse code to channel value
// Clamps the code and computes (2719 - code) * 16 / 17.
// ----------------------------------------------------------------------------
`default_nettype none

module kcfe_code_map
  import kcfe_pkg::*;
(
  input  wire logic [CODE_W-1:0] raw_code,
  output logic      [CODE_W-1:0] value
);

  logic [CODE_W-1:0] clamped;
  logic [CODE_W-1:0] diff;
  logic [15:0]       scaled;
  logic [31:0]       prod;

  always_comb begin
    clamped = (raw_code > CODE_TOP) ? CODE_TOP : raw_code;
    diff    = CODE_TOP - clamped;
    scaled  = {diff, 4'b0000};
    prod    = 32'(scaled) * 32'(RECIP_17);
    value   = prod[RECIP_SHIFT +: CODE_W];
  end

endmodule

`default_nettype wire

### rtl/keypad_channel_frame_encoder.sv
// ----------------------------------------------------------------------------
// keypad_channel_frame_encoder: sticky keypad payload to channel values
// Each accepted request sets out_valid; the channel value is registered on a slot's first request.
// Throughput: one request per cycle while out_stall does not hold a valid output; the output register is the held code.
// Each code is held for REPEATS requests across sync, low, mid, high slots.
// Reset (rst, synchronous): payload, counters and value cleared, sync slot next.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_channel_frame_encoder
  import kcfe_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic [CODE_W-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [KEY_W-1:0]  key_bits,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [CODE_W-1:0] channel_value
);

  logic [CODE_W-1:0] sync_code;
  logic [KEY_W-1:0]  sticky_payload;
  logic [REP_W-1:0]  repeat_count;
  logic [1:0]        slot_index;

  logic              accept;
  logic [KEY_W-1:0]  payload;
  logic [KEY_W-1:0]  clear_mask;
  logic [VAL_W-1:0]  v_low;
  logic [VAL_W-1:0]  v_mid;
  logic [VAL_W-1:0]  v_high;
  logic [VAL_W-1:0]  slot_val;
  logic [CODE_W-1:0] slot_code;
  logic [CODE_W-1:0] raw_code;
  logic [CODE_W-1:0] mapped;
  logic [REP_W-1:0]  repeat_inc;
  logic              first_tick;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    payload    = sticky_payload | key_bits;
    first_tick = (repeat_count == '0);
    repeat_inc = repeat_count + REP_W'(1);
    v_low      = payload[5:0];
    v_mid      = pick_wider(v_low, payload[10:6]);
    v_high     = pick_wider(v_mid, payload[15:11]);
    case (slot_index)
      SLOT_LOW: begin
        slot_val   = v_low;
        clear_mask = CLR_LOW;
      end
      SLOT_MID: begin
        slot_val   = v_mid;
        clear_mask = CLR_MID;
      end
      SLOT_HIGH: begin
        slot_val   = v_high;
        clear_mask = CLR_HIGH;
      end
      default: begin
        slot_val   = '0;
        clear_mask = '1;
      end
    endcase
    slot_code = {1'b0, slot_val, 5'b00000} + CODE_BASE;
    slot_code = slot_code + CODE_W'(slot_code[CODE_W-1:8]);
    raw_code  = (slot_index == SLOT_SYNC) ? sync_code : slot_code;
  end

  kcfe_code_map u_code_map (
    .raw_code (raw_code),
    .value    (mapped)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_code <= SYNC_RESET;
    end else if (cfg_write) begin
      sync_code <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sticky_payload <= '0;
      repeat_count   <= '0;
      slot_index     <= SLOT_SYNC;
      channel_value  <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
        if (first_tick) begin
          sticky_payload <= payload & clear_mask;
          channel_value  <= mapped;
          slot_index     <= slot_index + 2'd1;
        end else begin
          sticky_payload <= payload;
        end
        repeat_count <= (32'(repeat_inc) >= REPEATS) ? '0 : repeat_inc;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
